/* src/rwlt_pkg.sv */
// rwlt_pkg: operation codes and fixed field widths of the reader/writer lock table
// no dependencies

package rwlt_pkg;

   localparam int OP_W    = 3;
   localparam int OWNER_W = 16;
   localparam int COUNT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_TRY_WRITE     = 3'd0,
      OP_TRY_READ      = 3'd1,
      OP_RELEASE_WRITE = 3'd2,
      OP_RELEASE_READ  = 3'd3,
      OP_RELEASE_BOTH  = 3'd4,
      OP_QUERY_WRITE   = 3'd5,
      OP_QUERY_READ    = 3'd6
   } op_type;

endpackage

/* src/rwlt_if.sv */
// rwlt_req_if and rwlt_rsp_if: valid/ready channels of the lock table
// depends on rwlt_pkg for the field widths

interface rwlt_req_if import rwlt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [OWNER_W-1:0] owner;

   modport source (output valid, output operation, output owner, input ready);
   modport sink   (input valid, input operation, input owner, output ready);
endinterface

interface rwlt_rsp_if import rwlt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               answer;
   logic               table_full;
   logic [COUNT_W-1:0] reader_count;

   modport source (output valid, output answer, output table_full, output reader_count,
                   input ready);
   modport sink   (input valid, input answer, input table_full, input reader_count,
                   output ready);
endinterface

/* src/rwlt_slot_mem.sv */
// rwlt_slot_mem: reader slot owner store, one write and one read port,
// registered read data; no package dependency

module rwlt_slot_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/reader_writer_lock_table_unit.sv */
// reader_writer_lock_table_unit: owner-tracking reader/writer lock, built on rwlt_slot_mem
// writer ops, refused reads and code 7 answer in the cycle after the accepting beat;
// try_read scans from slot 0 up to the lowest free slot; release_read, release_both and
// query_read (when no writer holds the lock) scan every slot through the one read port
// one item at a time, the next beat can be taken in the same cycle as the response beat; reset
// clears the writer and all slot valid bits at once, the owner memory needs no clearing pass

module reader_writer_lock_table_unit import rwlt_pkg::*; #(
   parameter int READER_SLOTS = 16,
   parameter int OWNER_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   rwlt_req_if.sink    req_chan,
   rwlt_rsp_if.source  rsp_chan
);

   localparam int IDX_W = $clog2(READER_SLOTS);
   localparam int CNT_W = $clog2(READER_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [OWNER_BITS-1:0]   who_ff, who_in;
   logic [IDX_W-1:0]        chk_ff, chk_in;
   logic                    hit_ff, hit_in;
   logic [OWNER_BITS-1:0]   writer_ff, writer_in;
   logic [READER_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_answer_ff, rsp_answer_in;
   logic                    rsp_full_ff, rsp_full_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    rd_en, wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [OWNER_BITS-1:0]   rd_data;
   logic                    out_free, accept, last, slot_hit, slot_free;
   logic [OWNER_BITS-1:0]   req_who;
   op_type                  req_op;

   rwlt_slot_mem #(
      .DEPTH (READER_SLOTS),
      .WIDTH (OWNER_BITS)
   ) u_slot_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (chk_ff),
      .wr_data (who_ff)
   );

   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = (state_ff == ST_IDLE) && out_free;
   assign accept           = req_chan.valid && req_chan.ready;
   assign req_who          = OWNER_BITS'(req_chan.owner);
   assign req_op           = op_type'(req_chan.operation);
   assign last             = (chk_ff == IDX_W'(READER_SLOTS - 1));
   assign slot_free        = !valid_ff[chk_ff];
   assign slot_hit         = valid_ff[chk_ff] && (rd_data == who_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      who_in        = who_ff;
      chk_in        = chk_ff;
      hit_in        = hit_ff;
      writer_in     = writer_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               who_in        = req_who;
               rsp_answer_in = 1'b0;
               rsp_full_in   = 1'b0;
               rsp_count_in  = COUNT_W'(count_ff);
               case (req_op)
                  OP_TRY_WRITE: begin
                     if ((count_ff == '0) && (writer_ff == '0)) begin
                        writer_in = req_who;
                     end
                     rsp_answer_in = (writer_in == req_who);
                     rsp_valid_in  = 1'b1;
                  end
                  OP_TRY_READ: begin
                     if (writer_ff != '0) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == CNT_W'(READER_SLOTS)) begin
                        rsp_full_in  = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_RELEASE_WRITE: begin
                     if (writer_ff == req_who) begin
                        writer_in = '0;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_RELEASE_READ: begin
                     state_in = ST_SCAN;
                  end
                  OP_RELEASE_BOTH: begin
                     // writer release does not depend on the reader scan
                     if (writer_ff == req_who) begin
                        writer_in = '0;
                     end
                     state_in = ST_SCAN;
                  end
                  OP_QUERY_WRITE: begin
                     rsp_answer_in = (writer_ff == req_who);
                     rsp_valid_in  = 1'b1;
                  end
                  OP_QUERY_READ: begin
                     if (writer_ff != '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               if (state_in == ST_SCAN) begin
                  chk_in  = '0;
                  hit_in  = 1'b0;
                  rd_en   = 1'b1;
                  rd_addr = '0;
               end
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_TRY_READ) begin
               // lowest free slot takes the new reader
               if (slot_free) begin
                  wr_en            = 1'b1;
                  valid_in[chk_ff] = 1'b1;
                  count_in         = CNT_W'(count_ff + 1'b1);
                  hit_in           = 1'b1;
                  state_in         = ST_DONE;
               end else if (last) begin
                  state_in = ST_DONE;
               end else begin
                  chk_in  = IDX_W'(chk_ff + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(chk_ff + 1'b1);
               end
            end else begin
               if (slot_hit) begin
                  if (op_ff == OP_QUERY_READ) begin
                     hit_in = 1'b1;
                  end else begin
                     valid_in[chk_ff] = 1'b0;
                     count_in         = CNT_W'(count_ff - 1'b1);
                  end
               end
               if (last) begin
                  state_in = ST_DONE;
               end else begin
                  chk_in  = IDX_W'(chk_ff + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(chk_ff + 1'b1);
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = hit_ff;
               rsp_full_in   = 1'b0;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         writer_ff    <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         writer_ff    <= writer_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      who_ff        <= who_in;
      chk_ff        <= chk_in;
      hit_ff        <= hit_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.answer       = rsp_answer_ff;
   assign rsp_chan.table_full   = rsp_full_ff;
   assign rsp_chan.reader_count = rsp_count_ff;

endmodule

/* verif/rwlt_lock_checker.sv */
// rwlt_lock_checker: watches both channels of the lock table, keeps its own copy of the
// writer and reader slots, predicts every response beat and compares field by field
// depends on rwlt_pkg and the rwlt_req_if / rwlt_rsp_if interfaces
`timescale 1ns / 100ps

module rwlt_lock_checker import rwlt_pkg::*; #(
   parameter int READER_SLOTS = 16,
   parameter int OWNER_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   rwlt_req_if  req_mon,
   rwlt_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count,
   output int   checked_count,
   output int   full_count,
   output int   write_grant_count
);

   localparam logic [OWNER_W-1:0] OWNER_MASK = (OWNER_BITS >= OWNER_W) ? {OWNER_W{1'b1}} :
                                               ({OWNER_W{1'b1}} >> (OWNER_W - OWNER_BITS));
   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [OWNER_W-1:0] owner;
      logic               answer;
      logic               table_full;
      logic [COUNT_W-1:0] reader_count;
   } lock_outcome_type;

   logic [OWNER_W-1:0] held_writer;
   logic [OWNER_W-1:0] reader_owner [READER_SLOTS];
   logic               reader_live  [READER_SLOTS];
   lock_outcome_type   outstanding_outcomes [$];

   function automatic int live_readers();
      int n;
      n = 0;
      for (int i = 0; i < READER_SLOTS; i++) begin
         if (reader_live[i]) n++;
      end
      return n;
   endfunction

   function automatic void drop_reader(input logic [OWNER_W-1:0] who);
      for (int i = 0; i < READER_SLOTS; i++) begin
         if (reader_live[i] && reader_owner[i] == who) reader_live[i] = 1'b0;
      end
   endfunction

   function automatic void drop_writer(input logic [OWNER_W-1:0] who);
      if (held_writer == who) held_writer = '0;
   endfunction

   // applies one operation to the lock copy and returns the response it must produce
   function automatic lock_outcome_type apply_lock_op(input logic [OP_W-1:0] op,
                                                      input logic [OWNER_W-1:0] owner_in);
      lock_outcome_type   r;
      logic [OWNER_W-1:0] who;
      int                 free_slot;
      logic               hit;
      r         = '0;
      r.op      = op;
      r.owner   = owner_in;
      who       = owner_in & OWNER_MASK;
      free_slot = -1;
      hit       = 1'b0;
      case (op)
         OP_TRY_WRITE: begin
            if (live_readers() == 0 && held_writer == '0) held_writer = who;
            r.answer = (held_writer == who);
         end
         OP_TRY_READ: begin
            if (held_writer == '0) begin
               // lowest free slot wins
               for (int i = READER_SLOTS - 1; i >= 0; i--) begin
                  if (!reader_live[i]) free_slot = i;
               end
               if (free_slot >= 0) begin
                  reader_live[free_slot]  = 1'b1;
                  reader_owner[free_slot] = who;
                  r.answer                = 1'b1;
               end else begin
                  r.table_full = 1'b1;
               end
            end
         end
         OP_RELEASE_WRITE: drop_writer(who);
         OP_RELEASE_READ:  drop_reader(who);
         OP_RELEASE_BOTH: begin
            drop_reader(who);
            drop_writer(who);
         end
         OP_QUERY_WRITE: r.answer = (held_writer == who);
         OP_QUERY_READ: begin
            for (int i = 0; i < READER_SLOTS; i++) begin
               if (reader_live[i] && reader_owner[i] == who) hit = 1'b1;
            end
            r.answer = (held_writer == '0) && hit;
         end
         default: ;
      endcase
      r.reader_count = COUNT_W'(live_readers());
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) begin
         $display("[%0t] mismatch on response %0d: %s", $time, checked_count, what);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      lock_outcome_type want;
      if (reset) begin
         held_writer = '0;
         for (int i = 0; i < READER_SLOTS; i++) begin
            reader_live[i]  = 1'b0;
            reader_owner[i] = '0;
         end
         outstanding_outcomes.delete();
         error_count       = 0;
         checked_count     = 0;
         full_count        = 0;
         write_grant_count = 0;
      end else begin
         // the response side first: a beat never answers a request taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outstanding_outcomes.size() == 0) begin
               report_mismatch("response beat with no request waiting");
            end else begin
               want = outstanding_outcomes.pop_front();
               if (rsp_mon.answer !== want.answer)
                  report_mismatch($sformatf("op %0d owner %h: answer %b, want %b", want.op,
                                            want.owner, rsp_mon.answer, want.answer));
               if (rsp_mon.table_full !== want.table_full)
                  report_mismatch($sformatf("op %0d owner %h: table_full %b, want %b", want.op,
                                            want.owner, rsp_mon.table_full, want.table_full));
               if (rsp_mon.reader_count !== want.reader_count)
                  report_mismatch($sformatf("op %0d owner %h: reader_count %0d, want %0d",
                                            want.op, want.owner, rsp_mon.reader_count,
                                            want.reader_count));
               if (want.table_full) full_count++;
               if (want.answer && want.op == OP_TRY_WRITE) write_grant_count++;
               checked_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            outstanding_outcomes.insert(outstanding_outcomes.size(),
                                        apply_lock_op(req_mon.operation, req_mon.owner));
         end
      end
      pending_count = outstanding_outcomes.size();
   end

endmodule

/* verif/reader_writer_lock_table_unit_tb.sv */
// reader_writer_lock_table_unit_tb: drives lock operations into the table with random
// gaps and response back-pressure, and gives the verdict from the checker's counts
// depends on rwlt_pkg, rwlt_if, the lock table unit and rwlt_lock_checker
`timescale 1ns / 100ps

module reader_writer_lock_table_unit_tb;
   import rwlt_pkg::*;

   localparam int READER_SLOTS = 16;
   localparam int OWNER_BITS   = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int BLOCK_ITEMS  = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = READER_SLOTS + 8;
   localparam int HISTORY_MAX  = 48;
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   error_count;
   int   pending_count;
   int   checked_count;
   int   full_count;
   int   write_grant_count;
   logic send_calm = 1'b0;
   logic recv_calm = 1'b0;

   logic [OWNER_W-1:0] owner_pool [6] = '{16'h0001, 16'h0002, 16'h0003, 16'h8000,
                                          16'hFFFF, 16'h5A5A};
   logic [OWNER_W-1:0] recent_readers [$];

   rwlt_req_if req_chan ();
   rwlt_rsp_if rsp_chan ();

   reader_writer_lock_table_unit #(
      .READER_SLOTS(READER_SLOTS),
      .OWNER_BITS  (OWNER_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   rwlt_lock_checker #(
      .READER_SLOTS(READER_SLOTS),
      .OWNER_BITS  (OWNER_BITS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .full_count       (full_count),
      .write_grant_count(write_grant_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // called at a clock edge; returns at the edge that takes the beat, valid left high
   task automatic send_item(input logic [OP_W-1:0] op, input logic [OWNER_W-1:0] who);
      int gap;
      if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.owner     <= who;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_all_answered();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op(input traffic_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (roll < 55)      return OP_TRY_READ;
            else if (roll < 68) return OP_QUERY_READ;
            else if (roll < 78) return OP_TRY_WRITE;
            else if (roll < 86) return OP_RELEASE_READ;
            else if (roll < 93) return OP_RELEASE_WRITE;
            else                return OP_QUERY_WRITE;
         end
         MODE_DRAIN: begin
            if (roll < 35)      return OP_RELEASE_READ;
            else if (roll < 50) return OP_RELEASE_BOTH;
            else if (roll < 75) return OP_TRY_WRITE;
            else if (roll < 85) return OP_RELEASE_WRITE;
            else if (roll < 95) return OP_QUERY_WRITE;
            else                return OP_QUERY_READ;
         end
         default: begin
            if (roll == 0) return OP_UNUSED;
            return OP_W'($urandom_range(0, 6));
         end
      endcase
   endfunction

   // writers come only from the pool so that a held write lock is soon released again;
   // draining reuses owners that asked for reads so the table can empty
   function automatic logic [OWNER_W-1:0] pick_owner(input logic [OP_W-1:0] op,
                                                     input traffic_mode_type mode);
      logic [OWNER_W-1:0] who;
      if (mode == MODE_DRAIN && (op == OP_RELEASE_READ || op == OP_RELEASE_BOTH) &&
          recent_readers.size() != 0 && $urandom_range(0, 99) < 70) begin
         who = recent_readers.pop_front();
      end else if (op == OP_TRY_WRITE || $urandom_range(0, 99) < 85) begin
         who = owner_pool[$urandom_range(0, 5)];
      end else begin
         who = OWNER_W'($urandom_range(1, 65535));
      end
      if (op == OP_TRY_READ) begin
         recent_readers.insert(recent_readers.size(), who);
         if (recent_readers.size() > HISTORY_MAX) void'(recent_readers.pop_front());
      end
      return who;
   endfunction

   // response back-pressure, one draw per beat
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(negedge clock); while (!rsp_chan.valid);
         @(posedge clock);
      end
   end

   initial begin
      traffic_mode_type   mode;
      logic [OP_W-1:0]    op;
      logic [OWNER_W-1:0] who;
      mode               = MODE_MIX;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_TRY_WRITE;
      req_chan.owner     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // writer side: free lock, owner zero, unused code, repeat grant, refusals
      send_item(OP_QUERY_WRITE, 16'h0005);
      send_item(OP_TRY_WRITE, 16'h0000);
      send_item(OP_QUERY_WRITE, 16'h0000);
      send_item(OP_UNUSED, 16'hFFFF);
      send_item(OP_TRY_WRITE, 16'hFFFF);
      send_item(OP_TRY_WRITE, 16'hFFFF);
      send_item(OP_TRY_WRITE, 16'h0001);
      send_item(OP_TRY_READ, 16'hFFFF);
      send_item(OP_QUERY_READ, 16'hFFFF);
      send_item(OP_RELEASE_WRITE, 16'h0001);
      send_item(OP_RELEASE_BOTH, 16'hFFFF);
      // reader side: duplicates, write refused by readers, release by a stranger
      send_item(OP_TRY_READ, 16'h0001);
      send_item(OP_TRY_READ, 16'h0001);
      send_item(OP_TRY_WRITE, 16'h8000);
      send_item(OP_QUERY_READ, 16'h0001);
      send_item(OP_RELEASE_READ, 16'h1234);
      // fill every slot, get refused on a full table, then free the lowest slots
      for (int k = 0; k < READER_SLOTS - 2; k++) begin
         send_item(OP_TRY_READ, {k[3:0], 12'h5A5});
      end
      send_item(OP_TRY_READ, 16'h7FFF);
      send_item(OP_RELEASE_READ, 16'h0001);
      send_item(OP_TRY_READ, 16'hAAAA);
      wait_all_answered();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) mode = traffic_mode_type'($urandom_range(0, 2));
         if (n == RANDOM_ITEMS / 2) wait_all_answered();
         op  = pick_op(mode);
         who = pick_owner(op, mode);
         send_item(op, who);
      end

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d lock operations sent in %0d cycles, %0d responses checked",
               items_sent, cycle_count, checked_count);
      $display("%0d write grants, %0d reads refused on a full table, %0d mismatches",
               write_grant_count, full_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
